// ===== rtl/sbc_pkg.sv =====
// Shared widths, types and codes for the swept box collision block.
package sbc_pkg;

    localparam int COORD_BITS      = 11;
    localparam int VEL_BITS        = 8;
    localparam int MOVER_SIZE_BITS = 8;
    localparam int BOX_SIZE_BITS   = 10;

    localparam int SPAN_BITS = ((COORD_BITS > BOX_SIZE_BITS) ? COORD_BITS : BOX_SIZE_BITS) + 2;
    localparam int DEN_BITS  = VEL_BITS;
    localparam int PROD_BITS = SPAN_BITS + DEN_BITS + 1;
    localparam int NUM_BITS  = 2 * VEL_BITS;
    localparam int SUM_BITS  = ((COORD_BITS > VEL_BITS) ? COORD_BITS : VEL_BITS) + 2;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [COORD_BITS:0]   contact_t;
    typedef logic signed [VEL_BITS-1:0]   vel_t;
    typedef logic signed [VEL_BITS:0]     velw_t;
    typedef logic signed [SPAN_BITS-1:0]  span_t;
    typedef logic [DEN_BITS-1:0]          den_t;
    typedef logic signed [PROD_BITS-1:0]  prod_t;
    typedef logic [NUM_BITS-1:0]          num_t;
    typedef logic signed [SUM_BITS-1:0]   sum_t;

    typedef enum logic [1:0] {
        AXIS_NONE,
        AXIS_X,
        AXIS_Y
    } axis_t;

    // One axis after classification; lo/hi already flipped for negative velocity.
    typedef struct packed {
        logic  moving;
        logic  blocked;
        span_t lo;
        span_t hi;
        den_t  d;
    } slab_t;

    typedef struct packed {
        slab_t  sx;
        slab_t  sy;
        coord_t mover_x;
        coord_t mover_y;
        vel_t   vel_x;
        vel_t   vel_y;
    } item_t;

    typedef struct packed {
        logic   hit;
        axis_t  axis;
        coord_t mover_x;
        coord_t mover_y;
        vel_t   vel_x;
        vel_t   vel_y;
        den_t   ed;
        num_t   num_x;
        num_t   num_y;
    } div_in_t;

endpackage

// ===== rtl/sbc_front.sv =====
// Front end: takes input beats and classifies each axis into slab bounds.
module sbc_front
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  sbc_pkg::coord_t                     mover_x,
    input  sbc_pkg::coord_t                     mover_y,
    input  logic [sbc_pkg::MOVER_SIZE_BITS-1:0] mover_w,
    input  logic [sbc_pkg::MOVER_SIZE_BITS-1:0] mover_h,
    input  sbc_pkg::vel_t                       vel_x,
    input  sbc_pkg::vel_t                       vel_y,
    input  sbc_pkg::coord_t                     box_x,
    input  sbc_pkg::coord_t                     box_y,
    input  logic [sbc_pkg::BOX_SIZE_BITS-1:0]   box_w,
    input  logic [sbc_pkg::BOX_SIZE_BITS-1:0]   box_h,
    output logic                                item_valid,
    output sbc_pkg::item_t                      item,
    input  logic                                item_ready
);

    function automatic sbc_pkg::slab_t classify(
        input sbc_pkg::span_t pos,
        input sbc_pkg::span_t size,
        input sbc_pkg::vel_t  vel,
        input sbc_pkg::span_t bpos,
        input sbc_pkg::span_t bsize
    );
        sbc_pkg::span_t  n1;
        sbc_pkg::span_t  n2;
        sbc_pkg::velw_t  vw;
        sbc_pkg::slab_t  s;
        n1        = bpos - (pos + size);
        n2        = (bpos + bsize) - pos;
        vw        = sbc_pkg::velw_t'(vel);
        s.moving  = (vel != '0);
        // stationary axis: must already overlap, touching counts
        s.blocked = !s.moving && ((!n1[sbc_pkg::SPAN_BITS-1] && n1 != '0)
                                  || n2[sbc_pkg::SPAN_BITS-1]);
        if (vel[sbc_pkg::VEL_BITS-1])
        begin
            vw = -vw;
            n1 = -n1;
            n2 = -n2;
        end
        s.d  = vw[sbc_pkg::DEN_BITS-1:0];
        s.lo = (n1 < n2) ? n1 : n2;
        s.hi = (n1 > n2) ? n1 : n2;
        return s;
    endfunction

    logic           valid_reg;
    logic           valid_next;
    sbc_pkg::item_t item_reg;
    sbc_pkg::item_t item_next;
    sbc_pkg::item_t classified;

    assign in_ready   = !valid_reg || item_ready;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb
    begin
        classified.sx = classify(sbc_pkg::span_t'(mover_x), sbc_pkg::span_t'(mover_w), vel_x,
                                 sbc_pkg::span_t'(box_x), sbc_pkg::span_t'(box_w));
        classified.sy = classify(sbc_pkg::span_t'(mover_y), sbc_pkg::span_t'(mover_h), vel_y,
                                 sbc_pkg::span_t'(box_y), sbc_pkg::span_t'(box_h));
        classified.mover_x = mover_x;
        classified.mover_y = mover_y;
        classified.vel_x   = vel_x;
        classified.vel_y   = vel_y;
    end

    always_comb
    begin
        valid_next = valid_reg;
        item_next  = item_reg;
        if (in_valid && in_ready)
        begin
            valid_next = 1'b1;
            item_next  = classified;
        end
        else if (item_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

endmodule

// ===== rtl/sbc_queue.sv =====
// Short FIFO between the classifying front end and the back pipeline.
module sbc_queue
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    input  sbc_pkg::item_t push_item,
    output logic           push_ready,
    input  logic           pop,
    output logic           pop_valid,
    output sbc_pkg::item_t pop_item
);

    sbc_pkg::item_t                 mem_reg [sbc_pkg::QUEUE_DEPTH];
    logic [sbc_pkg::QPTR_BITS-1:0]  wr_ptr_reg;
    logic [sbc_pkg::QPTR_BITS-1:0]  wr_ptr_next;
    logic [sbc_pkg::QPTR_BITS-1:0]  rd_ptr_reg;
    logic [sbc_pkg::QPTR_BITS-1:0]  rd_ptr_next;
    logic [sbc_pkg::QCNT_BITS-1:0]  count_reg;
    logic [sbc_pkg::QCNT_BITS-1:0]  count_next;
    logic                           do_push;
    logic                           do_pop;

    assign push_ready = (count_reg != sbc_pkg::QCNT_BITS'(sbc_pkg::QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == sbc_pkg::QPTR_BITS'(sbc_pkg::QUEUE_DEPTH - 1))
                          ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == sbc_pkg::QPTR_BITS'(sbc_pkg::QUEUE_DEPTH - 1))
                          ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + sbc_pkg::QCNT_BITS'(do_push) - sbc_pkg::QCNT_BITS'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== rtl/sbc_slab.sv =====
// Back pipeline: combines the two slabs, decides the hit and forms the contact dividends.
module sbc_slab
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             adv,
    input  logic             item_valid,
    input  sbc_pkg::item_t   item,
    output logic             pop,
    output logic             div_valid,
    output sbc_pkg::div_in_t div_in
);

    typedef struct packed {
        logic            miss;
        sbc_pkg::coord_t mover_x;
        sbc_pkg::coord_t mover_y;
        sbc_pkg::vel_t   vel_x;
        sbc_pkg::vel_t   vel_y;
        sbc_pkg::den_t   dx;
        sbc_pkg::den_t   dy;
    } ctx_t;

    // entry en/ed, exit xn/xd
    typedef struct packed {
        sbc_pkg::span_t en;
        sbc_pkg::den_t  ed;
        sbc_pkg::span_t xn;
        sbc_pkg::den_t  xd;
        sbc_pkg::axis_t axis;
    } win_t;

    typedef struct packed {
        win_t           w;
        sbc_pkg::slab_t sy;
        ctx_t           c;
    } st1_t;

    typedef struct packed {
        win_t           w;
        sbc_pkg::slab_t sy;
        sbc_pkg::prod_t p_lo;
        sbc_pkg::prod_t p_en;
        sbc_pkg::prod_t p_hi;
        sbc_pkg::prod_t p_xn;
        ctx_t           c;
    } st2_t;

    typedef struct packed {
        win_t w;
        ctx_t c;
    } st3_t;

    typedef struct packed {
        win_t           w;
        sbc_pkg::prod_t a;
        sbc_pkg::prod_t b;
        ctx_t           c;
    } st4_t;

    function automatic sbc_pkg::prod_t smul(input sbc_pkg::span_t n, input sbc_pkg::den_t d);
        return sbc_pkg::prod_t'(n) * sbc_pkg::prod_t'(d);
    endfunction

    logic             s1_valid_reg, s1_valid_next;
    logic             s2_valid_reg, s2_valid_next;
    logic             s3_valid_reg, s3_valid_next;
    logic             s4_valid_reg, s4_valid_next;
    logic             s5_valid_reg, s5_valid_next;
    st1_t             s1_reg, s1_next;
    st2_t             s2_reg, s2_next;
    st3_t             s3_reg, s3_next;
    st4_t             s4_reg, s4_next;
    sbc_pkg::div_in_t s5_reg, s5_next;

    assign pop       = adv && item_valid;
    assign div_valid = s5_valid_reg;
    assign div_in    = s5_reg;

    // x axis against the initial window 0/1 .. 1/1
    always_comb
    begin
        s1_next.c.miss    = item.sx.blocked || item.sy.blocked;
        s1_next.c.mover_x = item.mover_x;
        s1_next.c.mover_y = item.mover_y;
        s1_next.c.vel_x   = item.vel_x;
        s1_next.c.vel_y   = item.vel_y;
        s1_next.c.dx      = item.sx.d;
        s1_next.c.dy      = item.sy.d;
        s1_next.sy        = item.sy;
        if (item.sx.moving && !item.sx.lo[sbc_pkg::SPAN_BITS-1] && item.sx.lo != '0)
        begin
            s1_next.w.en   = item.sx.lo;
            s1_next.w.ed   = item.sx.d;
            s1_next.w.axis = sbc_pkg::AXIS_X;
        end
        else
        begin
            s1_next.w.en   = '0;
            s1_next.w.ed   = sbc_pkg::den_t'(1);
            s1_next.w.axis = sbc_pkg::AXIS_NONE;
        end
        if (item.sx.moving && sbc_pkg::prod_t'(item.sx.hi) < sbc_pkg::prod_t'(item.sx.d))
        begin
            s1_next.w.xn = item.sx.hi;
            s1_next.w.xd = item.sx.d;
        end
        else
        begin
            s1_next.w.xn = sbc_pkg::span_t'(1);
            s1_next.w.xd = sbc_pkg::den_t'(1);
        end
    end

    always_comb
    begin
        s2_next.w    = s1_reg.w;
        s2_next.sy   = s1_reg.sy;
        s2_next.c    = s1_reg.c;
        s2_next.p_lo = smul(s1_reg.sy.lo, s1_reg.w.ed);
        s2_next.p_en = smul(s1_reg.w.en, s1_reg.sy.d);
        s2_next.p_hi = smul(s1_reg.sy.hi, s1_reg.w.xd);
        s2_next.p_xn = smul(s1_reg.w.xn, s1_reg.sy.d);
    end

    always_comb
    begin
        s3_next.w = s2_reg.w;
        s3_next.c = s2_reg.c;
        if (s2_reg.sy.moving && s2_reg.p_lo > s2_reg.p_en)
        begin
            s3_next.w.en   = s2_reg.sy.lo;
            s3_next.w.ed   = s2_reg.sy.d;
            s3_next.w.axis = sbc_pkg::AXIS_Y;
        end
        if (s2_reg.sy.moving && s2_reg.p_hi < s2_reg.p_xn)
        begin
            s3_next.w.xn = s2_reg.sy.hi;
            s3_next.w.xd = s2_reg.sy.d;
        end
    end

    always_comb
    begin
        s4_next.w = s3_reg.w;
        s4_next.c = s3_reg.c;
        s4_next.a = smul(s3_reg.w.en, s3_reg.w.xd);
        s4_next.b = smul(s3_reg.w.xn, s3_reg.w.ed);
    end

    // on a hit en <= ed, so the low bits of en carry it whole
    always_comb
    begin
        s5_next.hit     = !s4_reg.c.miss && !(s4_reg.a > s4_reg.b)
                          && !s4_reg.w.en[sbc_pkg::SPAN_BITS-1]
                          && (sbc_pkg::prod_t'(s4_reg.w.en) <= sbc_pkg::prod_t'(s4_reg.w.ed));
        s5_next.axis    = s4_reg.w.axis;
        s5_next.mover_x = s4_reg.c.mover_x;
        s5_next.mover_y = s4_reg.c.mover_y;
        s5_next.vel_x   = s4_reg.c.vel_x;
        s5_next.vel_y   = s4_reg.c.vel_y;
        s5_next.ed      = s4_reg.w.ed;
        s5_next.num_x   = sbc_pkg::num_t'(s4_reg.c.dx)
                          * sbc_pkg::num_t'(s4_reg.w.en[sbc_pkg::DEN_BITS-1:0]);
        s5_next.num_y   = sbc_pkg::num_t'(s4_reg.c.dy)
                          * sbc_pkg::num_t'(s4_reg.w.en[sbc_pkg::DEN_BITS-1:0]);
    end

    always_comb
    begin
        s1_valid_next = adv ? item_valid   : s1_valid_reg;
        s2_valid_next = adv ? s1_valid_reg : s2_valid_reg;
        s3_valid_next = adv ? s2_valid_reg : s3_valid_reg;
        s4_valid_next = adv ? s3_valid_reg : s4_valid_reg;
        s5_valid_next = adv ? s4_valid_reg : s5_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
            s3_valid_reg <= s3_valid_next;
            s4_valid_reg <= s4_valid_next;
            s5_valid_reg <= s5_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_reg <= s1_next;
            s2_reg <= s2_next;
            s3_reg <= s3_next;
            s4_reg <= s4_next;
            s5_reg <= s5_next;
        end
    end

endmodule

// ===== rtl/sbc_div.sv =====
// Back pipeline tail: one quotient bit per stage for both axes, then the output register.
module sbc_div
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   div_valid,
    input  sbc_pkg::div_in_t       div_in,
    output logic                   adv,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic                   hit,
    output sbc_pkg::contact_t      contact_x,
    output sbc_pkg::contact_t      contact_y,
    output sbc_pkg::velw_t         new_vel_x,
    output sbc_pkg::velw_t         new_vel_y
);

    typedef struct packed {
        sbc_pkg::den_t r;
        sbc_pkg::den_t nlo;
        sbc_pkg::den_t q;
    } lane_t;

    typedef struct packed {
        logic            hit;
        sbc_pkg::axis_t  axis;
        sbc_pkg::coord_t mover_x;
        sbc_pkg::coord_t mover_y;
        sbc_pkg::vel_t   vel_x;
        sbc_pkg::vel_t   vel_y;
        sbc_pkg::den_t   ed;
        lane_t           lx;
        lane_t           ly;
    } div_t;

    // restoring step; the upper dividend half is below the divisor on a hit
    function automatic lane_t lane_step(input lane_t l, input sbc_pkg::den_t d);
        logic [sbc_pkg::DEN_BITS:0] t;
        lane_t                      o;
        t     = {l.r, l.nlo[sbc_pkg::DEN_BITS-1]};
        o.nlo = l.nlo << 1;
        if (t >= {1'b0, d})
        begin
            o.r = sbc_pkg::den_t'(t - {1'b0, d});
            o.q = {l.q[sbc_pkg::DEN_BITS-2:0], 1'b1};
        end
        else
        begin
            o.r = sbc_pkg::den_t'(t);
            o.q = {l.q[sbc_pkg::DEN_BITS-2:0], 1'b0};
        end
        return o;
    endfunction

    function automatic sbc_pkg::contact_t contact(
        input sbc_pkg::coord_t pos,
        input sbc_pkg::vel_t   vel,
        input sbc_pkg::den_t   q
    );
        sbc_pkg::sum_t base;
        sbc_pkg::sum_t mag;
        sbc_pkg::sum_t total;
        base  = sbc_pkg::sum_t'(pos);
        mag   = sbc_pkg::sum_t'(q);
        total = vel[sbc_pkg::VEL_BITS-1] ? base - mag : base + mag;
        return sbc_pkg::contact_t'(total[sbc_pkg::COORD_BITS:0]);
    endfunction

    div_t                        first;
    div_t                        stage_in   [sbc_pkg::DEN_BITS];
    div_t                        stage_next [sbc_pkg::DEN_BITS];
    div_t                        stage_reg  [sbc_pkg::DEN_BITS];
    logic [sbc_pkg::DEN_BITS-1:0] valid_reg;
    logic [sbc_pkg::DEN_BITS-1:0] valid_next;
    div_t                        last;
    sbc_pkg::velw_t              vx_w;
    sbc_pkg::velw_t              vy_w;

    logic              out_valid_reg, out_valid_next;
    logic              hit_reg, hit_next;
    sbc_pkg::contact_t cx_reg, cx_next;
    sbc_pkg::contact_t cy_reg, cy_next;
    sbc_pkg::velw_t    nvx_reg, nvx_next;
    sbc_pkg::velw_t    nvy_reg, nvy_next;

    assign adv = !out_valid_reg || out_ready;

    always_comb
    begin
        first.hit     = div_in.hit;
        first.axis    = div_in.axis;
        first.mover_x = div_in.mover_x;
        first.mover_y = div_in.mover_y;
        first.vel_x   = div_in.vel_x;
        first.vel_y   = div_in.vel_y;
        first.ed      = div_in.ed;
        first.lx.r    = div_in.num_x[sbc_pkg::NUM_BITS-1:sbc_pkg::DEN_BITS];
        first.lx.nlo  = div_in.num_x[sbc_pkg::DEN_BITS-1:0];
        first.lx.q    = '0;
        first.ly.r    = div_in.num_y[sbc_pkg::NUM_BITS-1:sbc_pkg::DEN_BITS];
        first.ly.nlo  = div_in.num_y[sbc_pkg::DEN_BITS-1:0];
        first.ly.q    = '0;
    end

    for (genvar k = 0; k < sbc_pkg::DEN_BITS; k++)
    begin : g_stage
        if (k == 0)
        begin : g_head
            always_comb
            begin
                stage_in[k]   = first;
                valid_next[k] = adv ? div_valid : valid_reg[k];
            end
        end
        else
        begin : g_body
            always_comb
            begin
                stage_in[k]   = stage_reg[k-1];
                valid_next[k] = adv ? valid_reg[k-1] : valid_reg[k];
            end
        end

        always_comb
        begin
            stage_next[k]    = stage_in[k];
            stage_next[k].lx = lane_step(stage_in[k].lx, stage_in[k].ed);
            stage_next[k].ly = lane_step(stage_in[k].ly, stage_in[k].ed);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else
            begin
                valid_reg[k] <= valid_next[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                stage_reg[k] <= stage_next[k];
            end
        end
    end

    assign last = stage_reg[sbc_pkg::DEN_BITS-1];
    assign vx_w = sbc_pkg::velw_t'(last.vel_x);
    assign vy_w = sbc_pkg::velw_t'(last.vel_y);

    always_comb
    begin
        out_valid_next = adv ? valid_reg[sbc_pkg::DEN_BITS-1] : out_valid_reg;
        hit_next       = last.hit;
        cx_next        = last.hit ? contact(last.mover_x, last.vel_x, last.lx.q) : '0;
        cy_next        = last.hit ? contact(last.mover_y, last.vel_y, last.ly.q) : '0;
        nvx_next       = (last.hit && last.axis == sbc_pkg::AXIS_X) ? -vx_w : vx_w;
        nvy_next       = (last.hit && last.axis == sbc_pkg::AXIS_Y) ? -vy_w : vy_w;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            hit_reg <= hit_next;
            cx_reg  <= cx_next;
            cy_reg  <= cy_next;
            nvx_reg <= nvx_next;
            nvy_reg <= nvy_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign hit       = hit_reg;
    assign contact_x = cx_reg;
    assign contact_y = cy_reg;
    assign new_vel_x = nvx_reg;
    assign new_vel_y = nvy_reg;

endmodule

// ===== rtl/swept_box_collision_top.sv =====
// Path: front-end register, queue, slab stages s1..s5, then one divider stage per
// quotient bit and the output register; beats hold in place while the output stalls.
// Throughput: one beat per cycle while out_ready is high; the back pipeline and its
// divider advance and stall together, and the 4-entry queue absorbs front-end slack.
// Reset: asynchronous, clears all valid flags and the queue pointers; no clearing pass.
module swept_box_collision_top
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  sbc_pkg::coord_t                     mover_x,
    input  sbc_pkg::coord_t                     mover_y,
    input  logic [sbc_pkg::MOVER_SIZE_BITS-1:0] mover_w,
    input  logic [sbc_pkg::MOVER_SIZE_BITS-1:0] mover_h,
    input  sbc_pkg::vel_t                       vel_x,
    input  sbc_pkg::vel_t                       vel_y,
    input  sbc_pkg::coord_t                     box_x,
    input  sbc_pkg::coord_t                     box_y,
    input  logic [sbc_pkg::BOX_SIZE_BITS-1:0]   box_w,
    input  logic [sbc_pkg::BOX_SIZE_BITS-1:0]   box_h,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                hit,
    output sbc_pkg::contact_t                   contact_x,
    output sbc_pkg::contact_t                   contact_y,
    output sbc_pkg::velw_t                      new_vel_x,
    output sbc_pkg::velw_t                      new_vel_y
);

    logic             front_valid;
    sbc_pkg::item_t   front_item;
    logic             q_ready;
    logic             q_valid;
    sbc_pkg::item_t   q_item;
    logic             pop;
    logic             adv;
    logic             div_valid;
    sbc_pkg::div_in_t div_in;

    sbc_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .mover_x    (mover_x),
        .mover_y    (mover_y),
        .mover_w    (mover_w),
        .mover_h    (mover_h),
        .vel_x      (vel_x),
        .vel_y      (vel_y),
        .box_x      (box_x),
        .box_y      (box_y),
        .box_w      (box_w),
        .box_h      (box_h),
        .item_valid (front_valid),
        .item       (front_item),
        .item_ready (q_ready)
    );

    sbc_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_item  (front_item),
        .push_ready (q_ready),
        .pop        (pop),
        .pop_valid  (q_valid),
        .pop_item   (q_item)
    );

    sbc_slab u_slab
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .item_valid (q_valid),
        .item       (q_item),
        .pop        (pop),
        .div_valid  (div_valid),
        .div_in     (div_in)
    );

    sbc_div u_div
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .div_valid  (div_valid),
        .div_in     (div_in),
        .adv        (adv),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .hit        (hit),
        .contact_x  (contact_x),
        .contact_y  (contact_y),
        .new_vel_x  (new_vel_x),
        .new_vel_y  (new_vel_y)
    );

    a_miss_zero_contact : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !hit |-> contact_x == '0 && contact_y == '0)
        else $error("miss beat carries a non-zero contact point");

    a_empty_not_full : assert property (@(posedge clk) disable iff (!rst_n)
        !q_valid |-> q_ready)
        else $error("queue reports empty and full together");

    a_front_holds : assert property (@(posedge clk) disable iff (!rst_n)
        front_valid && !q_ready |=> front_valid)
        else $error("front end dropped a beat while the queue was full");

endmodule

// ===== verif/tb_swept_box_collision_top.sv =====
`timescale 1ns / 100ps
// Testbench for swept_box_collision_top: directed table, then random pairs against a predictor.
module tb_swept_box_collision_top;
    import sbc_pkg::*;

    localparam int RANDOM_BEATS = 600;
    localparam int DRAIN_CYCLES = 7 + VEL_BITS + 20;
    localparam int QUIET_LIMIT  = 3000;

    typedef struct {
        coord_t                     mx;
        coord_t                     my;
        logic [MOVER_SIZE_BITS-1:0] mw;
        logic [MOVER_SIZE_BITS-1:0] mh;
        vel_t                       vx;
        vel_t                       vy;
        coord_t                     bx;
        coord_t                     by;
        logic [BOX_SIZE_BITS-1:0]   bw;
        logic [BOX_SIZE_BITS-1:0]   bh;
    } pair_t;

    typedef struct {
        logic     hit;
        contact_t cx;
        contact_t cy;
        velw_t    nvx;
        velw_t    nvy;
    } outcome_t;

    typedef struct {
        pair_t    p;
        bit       typed_in;
        outcome_t o;
    } row_t;

    logic                       clk = 1'b0;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_ready;
    coord_t                     mover_x;
    coord_t                     mover_y;
    logic [MOVER_SIZE_BITS-1:0] mover_w;
    logic [MOVER_SIZE_BITS-1:0] mover_h;
    vel_t                       vel_x;
    vel_t                       vel_y;
    coord_t                     box_x;
    coord_t                     box_y;
    logic [BOX_SIZE_BITS-1:0]   box_w;
    logic [BOX_SIZE_BITS-1:0]   box_h;
    logic                       out_valid;
    logic                       out_ready;
    logic                       hit;
    contact_t                   contact_x;
    contact_t                   contact_y;
    velw_t                      new_vel_x;
    velw_t                      new_vel_y;

    row_t     directed_rows[$];
    outcome_t expected_outcomes[$];
    int       mismatches = 0;
    int       results_seen = 0;
    int       quiet_cycles = 0;
    int       stall_left = 0;
    int       in_idle_pct;
    int       out_idle_pct;

    swept_box_collision_top dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .mover_x   (mover_x),
        .mover_y   (mover_y),
        .mover_w   (mover_w),
        .mover_h   (mover_h),
        .vel_x     (vel_x),
        .vel_y     (vel_y),
        .box_x     (box_x),
        .box_y     (box_y),
        .box_w     (box_w),
        .box_h     (box_h),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .hit       (hit),
        .contact_x (contact_x),
        .contact_y (contact_y),
        .new_vel_x (new_vel_x),
        .new_vel_y (new_vel_y)
    );

    always #5 clk = ~clk;

    // One slab; returns 0 when a stationary axis does not overlap.
    function automatic bit sweep_axis(input longint pos, input longint size, input longint vel,
                                      input longint bpos, input longint bsize,
                                      input axis_t which,
                                      inout longint en, inout longint ed,
                                      inout longint xn, inout longint xd,
                                      inout axis_t entry_axis);
        longint n1;
        longint n2;
        longint d;
        longint lo;
        longint hi;
        if (vel == 0)
            return !((pos + size) < bpos || pos > (bpos + bsize));
        n1 = bpos - (pos + size);
        n2 = (bpos + bsize) - pos;
        d = vel;
        if (d < 0)
        begin
            d = -d;
            n1 = -n1;
            n2 = -n2;
        end
        lo = (n1 < n2) ? n1 : n2;
        hi = (n1 > n2) ? n1 : n2;
        if (lo * ed > en * d)
        begin
            en = lo;
            ed = d;
            entry_axis = which;
        end
        if (hi * xd < xn * d)
        begin
            xn = hi;
            xd = d;
        end
        return 1'b1;
    endfunction

    function automatic outcome_t predict_collision(input pair_t p);
        outcome_t r;
        longint   en;
        longint   ed;
        longint   xn;
        longint   xd;
        longint   mx;
        longint   my;
        longint   vx;
        longint   vy;
        axis_t    entry_axis;
        bit       ok;
        en = 0;
        ed = 1;
        xn = 1;
        xd = 1;
        mx = p.mx;
        my = p.my;
        vx = p.vx;
        vy = p.vy;
        entry_axis = AXIS_NONE;
        ok = sweep_axis(mx, p.mw, vx, p.bx, p.bw, AXIS_X, en, ed, xn, xd, entry_axis);
        if (ok)
            ok = sweep_axis(my, p.mh, vy, p.by, p.bh, AXIS_Y, en, ed, xn, xd, entry_axis);
        if (ok && en * xd > xn * ed)
            ok = 1'b0;
        if (ok && (en < 0 || en > ed))
            ok = 1'b0;
        r.hit = ok;
        r.cx  = '0;
        r.cy  = '0;
        r.nvx = velw_t'(vx);
        r.nvy = velw_t'(vy);
        if (ok)
        begin
            r.cx = contact_t'(mx + (vx * en) / ed);
            r.cy = contact_t'(my + (vy * en) / ed);
            if (entry_axis == AXIS_X)
                r.nvx = velw_t'(-vx);
            else if (entry_axis == AXIS_Y)
                r.nvy = velw_t'(-vy);
        end
        return r;
    endfunction

    function automatic pair_t make_pair(input int mx, input int my, input int mw, input int mh,
                                        input int vx, input int vy, input int bx, input int by,
                                        input int bw, input int bh);
        pair_t p;
        p.mx = coord_t'(mx);
        p.my = coord_t'(my);
        p.mw = mw[MOVER_SIZE_BITS-1:0];
        p.mh = mh[MOVER_SIZE_BITS-1:0];
        p.vx = vel_t'(vx);
        p.vy = vel_t'(vy);
        p.bx = coord_t'(bx);
        p.by = coord_t'(by);
        p.bw = bw[BOX_SIZE_BITS-1:0];
        p.bh = bh[BOX_SIZE_BITS-1:0];
        return p;
    endfunction

    function automatic void add_row(input pair_t p);
        row_t r;
        r.p = p;
        r.typed_in = 1'b0;
        r.o = '{1'b0, '0, '0, '0, '0};
        directed_rows.push_back(r);
    endfunction

    function automatic void add_typed(input pair_t p, input int h, input int cx, input int cy,
                                      input int nvx, input int nvy);
        row_t r;
        r.p = p;
        r.typed_in = 1'b1;
        r.o.hit = h[0];
        r.o.cx = contact_t'(cx);
        r.o.cy = contact_t'(cy);
        r.o.nvx = velw_t'(nvx);
        r.o.nvy = velw_t'(nvy);
        directed_rows.push_back(r);
    endfunction

    function automatic int pick_gap(input int pct);
        if (int'($urandom_range(0, 99)) >= pct)
            return 0;
        if ($urandom_range(0, 9) == 0)
            return int'($urandom_range(8, 40));
        return int'($urandom_range(1, 3));
    endfunction

    function automatic int pick_vel();
        if ($urandom_range(0, 9) == 0)
        begin
            case ($urandom_range(0, 4))
                0: return -128;
                1: return 127;
                2: return 1;
                3: return -1;
                default: return 0;
            endcase
        end
        return int'($urandom_range(0, 255)) - 128;
    endfunction

    function automatic int pick_size(input int maxv);
        int r;
        r = int'($urandom_range(0, 19));
        if (r < 14)
            return int'($urandom_range(0, 40));
        if (r < 18)
            return int'($urandom_range(0, maxv));
        return (r == 18) ? maxv : 0;
    endfunction

    // Place the static box around the mover's swept span so that hits and near misses dominate.
    function automatic int near_edge(input int pos, input int size, input int vel, input int bsize);
        int reach;
        int c;
        reach = (size + ((vel < 0) ? -vel : vel)) / 2 + bsize / 2 + 8;
        c = pos + size / 2 + vel / 2 - bsize / 2
            + int'($urandom_range(0, 2 * reach)) - reach;
        if (c > 1023)
            c = 1023;
        if (c < -1024)
            c = -1024;
        return c;
    endfunction

    function automatic pair_t random_pair();
        pair_t p;
        int    mode;
        int    mx;
        int    my;
        int    mw;
        int    mh;
        int    vx;
        int    vy;
        int    bw;
        int    bh;
        mode = int'($urandom_range(0, 9));
        if (mode < 2)
        begin
            p.mx = coord_t'($urandom);
            p.my = coord_t'($urandom);
            p.mw = MOVER_SIZE_BITS'($urandom);
            p.mh = MOVER_SIZE_BITS'($urandom);
            p.vx = vel_t'($urandom);
            p.vy = vel_t'($urandom);
            p.bx = coord_t'($urandom);
            p.by = coord_t'($urandom);
            p.bw = BOX_SIZE_BITS'($urandom);
            p.bh = BOX_SIZE_BITS'($urandom);
            return p;
        end
        vx = pick_vel();
        vy = pick_vel();
        if (mode == 2)
        begin
            if ($urandom_range(0, 1))
                vx = 0;
            else
                vy = 0;
        end
        mx = int'($urandom_range(0, 2047)) - 1024;
        my = int'($urandom_range(0, 2047)) - 1024;
        mw = pick_size(255);
        mh = pick_size(255);
        bw = pick_size(1023);
        bh = pick_size(1023);
        return make_pair(mx, my, mw, mh, vx, vy, near_edge(mx, mw, vx, bw),
                         near_edge(my, mh, vy, bh), bw, bh);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic send_beat(input row_t r);
        int gap;
        gap = pick_gap(in_idle_pct);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        mover_x  <= r.p.mx;
        mover_y  <= r.p.my;
        mover_w  <= r.p.mw;
        mover_h  <= r.p.mh;
        vel_x    <= r.p.vx;
        vel_y    <= r.p.vy;
        box_x    <= r.p.bx;
        box_y    <= r.p.by;
        box_w    <= r.p.bw;
        box_h    <= r.p.bh;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (r.typed_in)
            expected_outcomes.push_back(r.o);
        else
            expected_outcomes.push_back(predict_collision(r.p));
        @(negedge clk);
    endtask

    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            out_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else
        begin
            out_ready <= 1'b1;
            stall_left <= pick_gap(out_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        outcome_t want;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (expected_outcomes.size() == 0)
                report_mismatch($sformatf("beat %0d arrived with nothing expected", results_seen));
            else
            begin
                want = expected_outcomes.pop_front();
                if (hit !== want.hit)
                    report_mismatch($sformatf("beat %0d hit %0b, want %0b",
                                              results_seen, hit, want.hit));
                if (contact_x !== want.cx)
                    report_mismatch($sformatf("beat %0d contact_x %0d, want %0d",
                                              results_seen, contact_x, want.cx));
                if (contact_y !== want.cy)
                    report_mismatch($sformatf("beat %0d contact_y %0d, want %0d",
                                              results_seen, contact_y, want.cy));
                if (new_vel_x !== want.nvx)
                    report_mismatch($sformatf("beat %0d new_vel_x %0d, want %0d",
                                              results_seen, new_vel_x, want.nvx));
                if (new_vel_y !== want.nvy)
                    report_mismatch($sformatf("beat %0d new_vel_y %0d, want %0d",
                                              results_seen, new_vel_y, want.nvy));
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == QUIET_LIMIT)
            begin
                $display("swept_box_collision_top test failed");
                $finish;
            end
        end
    end

    initial
    begin
        row_t r;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        out_ready = 1'b0;
        mover_x   = '0;
        mover_y   = '0;
        mover_w   = '0;
        mover_h   = '0;
        vel_x     = '0;
        vel_y     = '0;
        box_x     = '0;
        box_y     = '0;
        box_w     = '0;
        box_h     = '0;
        in_idle_pct  = 25;
        out_idle_pct = 25;

        // stationary: overlap, gap, touching edges
        add_typed(make_pair(0, 0, 10, 10, 0, 0, 5, 5, 10, 10), 1, 0, 0, 0, 0);
        add_typed(make_pair(0, 0, 10, 10, 0, 0, 50, 0, 10, 10), 0, 0, 0, 0, 0);
        add_typed(make_pair(0, 0, 10, 10, 0, 0, 10, 10, 5, 5), 1, 0, 0, 0, 0);
        // entry just past the end of the step
        add_typed(make_pair(0, 0, 10, 10, 10, 0, 21, 0, 10, 10), 0, 0, 0, 10, 0);
        // already overlapping while moving: no entry axis, no reflection
        add_typed(make_pair(0, 0, 10, 10, 5, 0, 0, 0, 10, 10), 1, 0, 0, 5, 0);
        add_typed(make_pair(20, 0, 10, 10, 5, 0, 0, 0, 10, 10), 0, 0, 0, 5, 0);
        add_typed(make_pair(0, 0, 10, 10, 20, 0, 20, 100, 10, 10), 0, 0, 0, 20, 0);
        add_typed(make_pair(-1024, -1024, 255, 255, 127, 127, 1023, 1023, 1023, 1023),
                  0, 0, 0, 127, 127);
        add_typed(make_pair(1023, 1023, 255, 255, 127, 127, 1023, 1023, 1023, 1023),
                  1, 1023, 1023, 127, 127);
        add_typed(make_pair(-1024, -1024, 0, 0, -128, -128, -1024, -1024, 0, 0),
                  1, -1024, -1024, -128, -128);
        add_typed(make_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, 0, 0, 0, 0);
        add_typed(make_pair(0, 0, 10, 10, -128, 0, 200, 0, 10, 10), 0, 0, 0, -128, 0);
        add_row(make_pair(0, 0, 10, 10, 20, 0, 20, 0, 10, 10));
        add_row(make_pair(0, 0, 10, 10, 10, 0, 20, 0, 10, 10));
        add_row(make_pair(100, 0, 10, 10, -50, 0, 60, 0, 20, 10));
        add_row(make_pair(0, 0, 0, 10, -128, 0, -200, 0, 100, 10));
        add_row(make_pair(0, 0, 10, 10, 0, 30, 0, 25, 10, 10));
        add_row(make_pair(0, 0, 10, 10, 20, 20, 15, 18, 10, 10));
        // entry equal to exit
        add_row(make_pair(0, 0, 10, 0, 10, -10, 15, -5, 10, 0));
        // contact division truncates toward zero
        add_row(make_pair(0, 0, 50, 0, -5, 7, -20, 3, 100, 10));
        add_row(make_pair(1000, 0, 0, 10, 127, 0, 1023, 0, 0, 10));
        add_row(make_pair(0, 100, 10, 0, 0, -128, 0, -20, 10, 100));
        add_row(make_pair(0, 0, 10, 10, 5, 0, 10, 0, 10, 10));

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_rows[i])
            send_beat(directed_rows[i]);

        r.typed_in = 1'b0;
        r.o = '{1'b0, '0, '0, '0, '0};
        for (int i = 0; i < RANDOM_BEATS; i++)
        begin
            if (i % 100 == 0)
            begin
                case ($urandom_range(0, 2))
                    0: in_idle_pct = 0;
                    1: in_idle_pct = 15;
                    default: in_idle_pct = 40;
                endcase
                case ($urandom_range(0, 2))
                    0: out_idle_pct = 0;
                    1: out_idle_pct = 15;
                    default: out_idle_pct = 40;
                endcase
            end
            r.p = random_pair();
            send_beat(r);
        end
        in_valid <= 1'b0;

        while (expected_outcomes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("swept_box_collision_top test passed");
        else
            $display("swept_box_collision_top test failed");
        $finish;
    end

endmodule

// ===== swept_box_collision_top.f =====
rtl/sbc_pkg.sv
rtl/sbc_front.sv
rtl/sbc_queue.sv
rtl/sbc_slab.sv
rtl/sbc_div.sv
rtl/swept_box_collision_top.sv
verif/tb_swept_box_collision_top.sv
